// ===== hdl/afb_pkg.sv =====
// Shared constants, types and table-building functions for the activation unit.
`timescale 1ns / 1ps
package afb_pkg;

	localparam int TABLE_POINTS_DEF = 256;
	localparam int FRAC_BITS_DEF    = 12;
	localparam int EXP_BITS         = 30;
	localparam int TAYLOR_TERMS     = 24;
	localparam int DATA_W           = 16;
	localparam int MODE_W           = 2;
	localparam int APB_DATA_W       = 32;
	localparam int APB_ADDR_W       = 3;

	localparam logic [MODE_W-1:0] MODE_SIGMOID  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TANH     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd2;

	localparam logic OP_FORWARD  = 1'b0;
	localparam logic OP_BACKWARD = 1'b1;

	// word index bit of paddr: 0 selects the mode register
	localparam logic REG_MODE = 1'b0;

	typedef struct packed {
		logic                     op;
		logic [MODE_W-1:0]        mode;
		logic                     last;
		logic signed [DATA_W-1:0] z;
		logic signed [DATA_W-1:0] g;
	} afb_ctl_t;

	// restoring long division; only evaluated while the table constants are built
	function automatic longint unsigned afb_udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		int              b;
		quo = 64'd0;
		rem = 64'd0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^(-step) in Q30 from a truncated Taylor series; h is the step in Q30
	function automatic longint unsigned afb_exp_q(input longint unsigned h);
		longint unsigned one30;
		longint unsigned term;
		longint          sum;
		int              n;
		one30 = 64'd1 << EXP_BITS;
		term  = one30;
		sum   = longint'(one30);
		for (n = 1; n <= TAYLOR_TERMS; n++) begin
			term = afb_udiv((term * h) >> EXP_BITS, 64'(n));
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return (sum > 0) ? longint'(sum) : 64'd0;
	endfunction

	// sigmoid table entry k: 2^(F+30) / (2^30 + e^(-k*step)), rounded
	function automatic longint unsigned afb_rom_entry(input int k, input longint unsigned q,
		input int frac);
		longint unsigned one30;
		longint unsigned e;
		longint unsigned den;
		longint unsigned num;
		int              j;
		one30 = 64'd1 << EXP_BITS;
		e     = one30;
		for (j = 0; j < k; j++) begin
			e = (e * q + (one30 >> 1)) >> EXP_BITS;
		end
		den = one30 + e;
		num = 64'd1 << (frac + EXP_BITS);
		return afb_udiv(num + (den >> 1), den);
	endfunction

endpackage

// ===== hdl/activation_forward_backward_unit.sv =====
// Top level of the sigmoid/tanh/identity activation unit with derivative path.
//
// channel   dir  handshake          contents
// s_*       in   s_tvalid/s_tready  tdata: pre_activation, upstream_gradient; tuser: op;
//                                    tlast: last_element
// m_*       out  m_tvalid/m_tready  tdata: result_value; tuser: saturated; tlast: last_out
// apb       in   psel/penable       mode register at byte address 0
//
// One transaction per cycle sustained while m_tready is high; eight register stages.
// The table lookup, interpolation multiply and two gradient multiplies each own a stage.
// Reset clears every stage valid bit and sets the mode to sigmoid.
// On a stall a stage holds while its successor is full; bubbles still fill, so
// s_tready stays high until all eight stages hold a transaction.
`timescale 1ns / 1ps
module activation_forward_backward_unit import afb_pkg::*; #(
	parameter int TABLE_POINTS = TABLE_POINTS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [2*DATA_W-1:0]   s_tdata,  // [15:0] pre_activation, [31:16] upstream_gradient
	input  logic                  s_tuser,  // [0] op
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_W-1:0]     m_tdata,  // [15:0] result_value
	output logic                  m_tuser,  // [0] saturated
	output logic                  m_tlast
);

	logic [MODE_W-1:0]          mode;
	afb_ctl_t                   in_ctl;
	afb_ctl_t                   mid_ctl;
	logic                       mid_valid;
	logic                       mid_ready;
	logic signed [FRAC_BITS+1:0] mid_act;

	afb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode)
	);

	always_comb begin
		in_ctl.op   = s_tuser;
		in_ctl.mode = mode;
		in_ctl.last = s_tlast;
		in_ctl.z    = s_tdata[DATA_W-1:0];
		in_ctl.g    = s_tdata[2*DATA_W-1:DATA_W];
	end

	afb_sigmoid #(
		.TABLE_POINTS (TABLE_POINTS),
		.FRAC_BITS    (FRAC_BITS)
	) u_sigmoid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_ctl    (in_ctl),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_ctl   (mid_ctl),
		.out_act   (mid_act)
	);

	afb_grad #(
		.FRAC_BITS (FRAC_BITS)
	) u_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_ctl    (mid_ctl),
		.in_act    (mid_act),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (m_tdata),
		.out_sat   (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

// ===== hdl/afb_cfg.sv =====
// APB register block holding the activation mode.
`timescale 1ns / 1ps
module afb_cfg import afb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [MODE_W-1:0]     mode
);

	logic [MODE_W-1:0] mode_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SIGMOID;
		end else if (wr_en) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1] == REG_MODE) begin
			prdata = APB_DATA_W'(mode_q);
		end
	end

	assign mode = mode_q;

endmodule

// ===== hdl/afb_sigmoid.sv =====
// Sigmoid/tanh forward path: argument scaling, table lookup, interpolation (stages 1-4).
`timescale 1ns / 1ps
module afb_sigmoid import afb_pkg::*; #(
	parameter int TABLE_POINTS = TABLE_POINTS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  afb_ctl_t                    in_ctl,
	output logic                        out_valid,
	input  logic                        out_ready,
	output afb_ctl_t                    out_ctl,
	output logic signed [FRAC_BITS+1:0] out_act
);

	localparam int X_W   = DATA_W + 1;
	localparam int TP_W  = $clog2(TABLE_POINTS + 1);
	localparam int IDX_W = $clog2(TABLE_POINTS);
	localparam int SH    = FRAC_BITS + 4;
	localparam int P_W   = (X_W + TP_W > SH) ? X_W + TP_W : SH + 1;
	localparam int R_W   = FRAC_BITS + 1;
	localparam int ACT_W = FRAC_BITS + 2;
	localparam int PR_W  = R_W + SH;
	localparam longint unsigned H = (64'd16 << EXP_BITS) / TABLE_POINTS;
	localparam longint unsigned Q = afb_exp_q(H);
	localparam logic [R_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// table: lo holds entries 0..N-1, hi holds entries 1..N
	logic [R_W-1:0] rom_lo [TABLE_POINTS];
	logic [R_W-1:0] rom_hi [TABLE_POINTS];

	for (genvar k = 0; k < TABLE_POINTS; k++) begin : g_rom
		assign rom_lo[k] = R_W'(afb_rom_entry(k, Q, FRAC_BITS));
		assign rom_hi[k] = R_W'(afb_rom_entry(k + 1, Q, FRAC_BITS));
	end

	// argument: z for sigmoid, 2z for tanh
	logic signed [X_W-1:0] x;
	logic [X_W-1:0]        a;
	logic [P_W-1:0]        p;
	logic [P_W-SH-1:0]     idx_full;
	logic                  clip;

	always_comb begin
		if (in_ctl.mode == MODE_TANH) begin
			x = {in_ctl.z, 1'b0};
		end else begin
			x = {in_ctl.z[DATA_W-1], in_ctl.z};
		end
		a        = x[X_W-1] ? (X_W'(0) - x) : x;
		p        = P_W'(a) * P_W'(TABLE_POINTS);
		idx_full = p[P_W-1:SH];
		clip     = 32'(idx_full) >= 32'(TABLE_POINTS);
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [IDX_W-1:0] idx_s1;
	logic [SH-1:0]    frac_s1;
	logic             clip_s1;
	logic             neg_s1;
	afb_ctl_t         ctl_s1;

	logic [R_W-1:0]   lo_s2;
	logic [R_W-1:0]   diff_s2;
	logic [SH-1:0]    frac_s2;
	logic             neg_s2;
	afb_ctl_t         ctl_s2;

	logic [R_W-1:0]   lo_s3;
	logic [PR_W-1:0]  prod_s3;
	logic             neg_s3;
	afb_ctl_t         ctl_s3;

	logic signed [ACT_W-1:0] act_s4;
	afb_ctl_t                ctl_s4;

	// a stage takes new data when it is empty or its successor moves
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	logic [R_W-1:0] lo_sel;
	logic [R_W-1:0] hi_sel;
	logic [R_W-1:0] mag;
	logic [R_W-1:0] s_val;

	always_comb begin
		if (clip_s1) begin
			lo_sel = rom_hi[TABLE_POINTS-1];
			hi_sel = rom_hi[TABLE_POINTS-1];
		end else begin
			lo_sel = rom_lo[idx_s1];
			hi_sel = rom_hi[idx_s1];
		end
		mag   = lo_s3 + R_W'(prod_s3 >> SH);
		s_val = neg_s3 ? (ONE - mag) : mag;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			idx_s1  <= IDX_W'(idx_full);
			frac_s1 <= p[SH-1:0];
			clip_s1 <= clip;
			neg_s1  <= x[X_W-1];
			ctl_s1  <= in_ctl;
		end
		if (rdy_s2 && v_s1) begin
			lo_s2   <= lo_sel;
			diff_s2 <= hi_sel - lo_sel;
			frac_s2 <= frac_s1;
			neg_s2  <= neg_s1;
			ctl_s2  <= ctl_s1;
		end
		if (rdy_s3 && v_s2) begin
			lo_s3   <= lo_s2;
			prod_s3 <= PR_W'(diff_s2) * PR_W'(frac_s2);
			neg_s3  <= neg_s2;
			ctl_s3  <= ctl_s2;
		end
		if (rdy_s4 && v_s3) begin
			if (ctl_s3.mode == MODE_TANH) begin
				act_s4 <= ACT_W'({s_val, 1'b0}) - ACT_W'(ONE);
			end else begin
				act_s4 <= ACT_W'(s_val);
			end
			ctl_s4 <= ctl_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_ctl   = ctl_s4;
	assign out_act   = act_s4;

endmodule

// ===== hdl/afb_grad.sv =====
// Derivative, gradient product, rounding and saturation (stages 5-8).
`timescale 1ns / 1ps
module afb_grad import afb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  afb_ctl_t                    in_ctl,
	input  logic signed [FRAC_BITS+1:0] in_act,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [DATA_W-1:0]           out_value,
	output logic                        out_sat,
	output logic                        out_last
);

	localparam int ACT_W = FRAC_BITS + 2;
	localparam int M_W   = 2 * ACT_W;
	localparam int G_W   = DATA_W + ACT_W;
	localparam logic signed [ACT_W-1:0] ONE_A  = ACT_W'(1) << FRAC_BITS;
	localparam logic signed [M_W-1:0]   HALF_M = M_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [G_W-1:0]   HALF_G = G_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [G_W-1:0]   MAX_V  = G_W'(32767);
	localparam logic signed [G_W-1:0]   MIN_V  = -G_W'(32768);

	logic v_s5, v_s6, v_s7, v_s8;
	logic rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	logic signed [M_W-1:0]   m_s5;
	logic signed [ACT_W-1:0] act_s5;
	afb_ctl_t                ctl_s5;

	logic signed [ACT_W-1:0] der_s6;
	logic signed [ACT_W-1:0] act_s6;
	afb_ctl_t                ctl_s6;

	logic signed [G_W-1:0]   gp_s7;
	logic signed [ACT_W-1:0] act_s7;
	afb_ctl_t                ctl_s7;

	logic [DATA_W-1:0] value_s8;
	logic              sat_s8;
	logic              last_s8;

	assign rdy_s8   = !v_s8 || out_ready;
	assign rdy_s7   = !v_s7 || rdy_s8;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign in_ready = rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= in_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	// sigmoid: s*(1-s); tanh: t*t
	logic signed [M_W-1:0] mul_a;
	logic signed [M_W-1:0] mul_b;
	logic signed [M_W-1:0] rs;
	logic signed [G_W-1:0] r;

	always_comb begin
		mul_a = M_W'(in_act);
		if (in_ctl.mode == MODE_SIGMOID) begin
			mul_b = M_W'(ONE_A - in_act);
		end else begin
			mul_b = M_W'(in_act);
		end
		rs = (m_s5 + HALF_M) >>> FRAC_BITS;

		if (ctl_s7.mode inside {MODE_SIGMOID, MODE_TANH}) begin
			if (ctl_s7.op == OP_BACKWARD) begin
				r = (gp_s7 + HALF_G) >>> FRAC_BITS;
			end else begin
				r = G_W'(act_s7);
			end
		end else begin
			// identity, and the unused mode code
			r = (ctl_s7.op == OP_BACKWARD) ? G_W'(ctl_s7.g) : G_W'(ctl_s7.z);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			m_s5   <= mul_a * mul_b;
			act_s5 <= in_act;
			ctl_s5 <= in_ctl;
		end
		if (rdy_s6 && v_s5) begin
			if (ctl_s5.mode == MODE_SIGMOID) begin
				der_s6 <= ACT_W'(rs);
			end else begin
				der_s6 <= ONE_A - ACT_W'(rs);
			end
			act_s6 <= act_s5;
			ctl_s6 <= ctl_s5;
		end
		if (rdy_s7 && v_s6) begin
			gp_s7  <= G_W'(ctl_s6.g) * G_W'(der_s6);
			act_s7 <= act_s6;
			ctl_s7 <= ctl_s6;
		end
		if (rdy_s8 && v_s7) begin
			if (r > MAX_V) begin
				value_s8 <= DATA_W'(MAX_V);
				sat_s8   <= 1'b1;
			end else if (r < MIN_V) begin
				value_s8 <= DATA_W'(MIN_V);
				sat_s8   <= 1'b1;
			end else begin
				value_s8 <= DATA_W'(r);
				sat_s8   <= 1'b0;
			end
			last_s8 <= ctl_s7.last;
		end
	end

	assign out_valid = v_s8;
	assign out_value = value_s8;
	assign out_sat   = sat_s8;
	assign out_last  = last_s8;

endmodule

// ===== hdl/afb_checker.sv =====
// Port-level checks for the activation unit, bound to the top level.
`timescale 1ns / 1ps
module afb_checker import afb_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic                  pready,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [DATA_W-1:0]     m_tdata,
	input logic                  m_tuser,
	input logic                  m_tlast
);

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 16'h7fff || m_tdata == 16'h8000)
		else $error("saturated result is not at a range limit");

	a_mode_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[APB_ADDR_W-1] == REG_MODE
		|=> paddr[APB_ADDR_W-1] != REG_MODE || prdata[MODE_W-1:0] == $past(pwdata[MODE_W-1:0]))
		else $error("mode register readback mismatch");

endmodule

bind activation_forward_backward_unit afb_checker u_afb_checker (.*);
